FILE: sv/sswr_pkg.sv
// ----------------------------------------------------------------------------
// Skid-steer wheel rpm package
// Register indexes and fixed field widths shared by the wheel rpm modules.
// ----------------------------------------------------------------------------
package sswr_pkg;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SAFE_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINEAR_LIMIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANGULAR_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRACK_SPAN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GEAR_RATIO    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_CIRC    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MOTOR_MAX_RPM = 3'd6;

  // Register and field widths.
  localparam int VEL_W    = 32;
  localparam int MAG_W    = 31;
  localparam int TRACK_W  = 25;
  localparam int RATIO_W  = 31;
  localparam int CIRC_W   = 31;
  localparam int MAXRPM_W = 16;
  localparam int RPM_W    = 32;

  // Seconds per minute, and the width of ratio times sixty.
  localparam int RATIO_MUL = 60;
  localparam int R60_W     = RATIO_W + 6;

  // floor(2^32 / 5), used to divide by five with one correction step.
  localparam logic [31:0] DIV5_RECIP = 32'h3333_3333;

endpackage

FILE: sv/sswr_mul.sv
// ----------------------------------------------------------------------------
// Pipelined wide multiplier
// Splits both operands in halves; partial products in the first stage,
// their sum in the second. A sideband word travels along with the valid bit.
// ----------------------------------------------------------------------------
module sswr_mul #(
  parameter int AW     = 40,
  parameter int BW     = 40,
  parameter int SIDE_W = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [AW-1:0]        a,
  input  logic [BW-1:0]        b,
  input  logic [SIDE_W-1:0]    in_side,
  output logic                 out_valid,
  output logic [AW+BW-1:0]     prod,
  output logic [SIDE_W-1:0]    out_side
);

  localparam int AL = AW / 2;
  localparam int AH = AW - AL;
  localparam int BL = BW / 2;
  localparam int BH = BW - BL;
  localparam int PW = AW + BW;

  logic              v1;
  logic [SIDE_W-1:0] side1;
  logic [AL+BL-1:0]  pll;
  logic [AL+BH-1:0]  plh;
  logic [AH+BL-1:0]  phl;
  logic [AH+BH-1:0]  phh;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    pll      <= (AL+BL)'(a[AL-1:0]) * (AL+BL)'(b[BL-1:0]);
    plh      <= (AL+BH)'(a[AL-1:0]) * (AL+BH)'(b[BW-1:BL]);
    phl      <= (AH+BL)'(a[AW-1:AL]) * (AH+BL)'(b[BL-1:0]);
    phh      <= (AH+BH)'(a[AW-1:AL]) * (AH+BH)'(b[BW-1:BL]);
    side1    <= in_side;
    prod     <= PW'(pll) + (PW'(plh) << BL) + (PW'(phl) << AL) + (PW'(phh) << (AL + BL));
    out_side <= side1;
  end

endmodule

FILE: sv/sswr_div.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage. The caller supplies the upper numerator part
// already below the divisor, so the quotient fits in QW bits.
// ----------------------------------------------------------------------------
module sswr_div #(
  parameter int QW     = 32,
  parameter int DW     = 32,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [DW-1:0]     in_rem,
  input  logic [QW-1:0]     in_num,
  input  logic [DW-1:0]     in_dvs,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [QW-1:0]     quo,
  output logic [SIDE_W-1:0] out_side
);

  logic              vld [QW];
  logic [DW-1:0]     rem [QW];
  logic [QW-1:0]     nq  [QW];
  logic [DW-1:0]     dvs [QW];
  logic [SIDE_W-1:0] sd  [QW];

  genvar k;
  for (k = 0; k < QW; k++) begin : g_stage
    logic              pv;
    logic [DW-1:0]     prem;
    logic [DW-1:0]     pdvs;
    logic [QW-1:0]     pnq;
    logic [SIDE_W-1:0] psd;
    logic [DW:0]       trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign pv   = in_valid;
      assign prem = in_rem;
      assign pdvs = in_dvs;
      assign pnq  = in_num;
      assign psd  = in_side;
    end else begin : g_next
      assign pv   = vld[k-1];
      assign prem = rem[k-1];
      assign pdvs = dvs[k-1];
      assign pnq  = nq[k-1];
      assign psd  = sd[k-1];
    end

    // Shift in the next numerator bit and subtract when it fits.
    assign trial = {prem, pnq[QW-1]};
    assign ge    = trial >= {1'b0, pdvs};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      rem[k] <= ge ? DW'(trial - {1'b0, pdvs}) : trial[DW-1:0];
      nq[k]  <= {pnq[QW-2:0], ge};
      dvs[k] <= pdvs;
      sd[k]  <= psd;
    end
  end

  assign out_valid = vld[QW-1];
  assign quo       = nq[QW-1];
  assign out_side  = sd[QW-1];

`ifndef SYNTHESIS
  // The remainder left after the last step is always below the divisor.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (rem[QW-1] < dvs[QW-1]))
    else $error("sswr_div: final remainder not below divisor");
`endif

endmodule

FILE: sv/sswr_topcalc.sv
// ----------------------------------------------------------------------------
// Top wheel speed calculator
// Serial divider for circumference * max_rpm / (ratio * 60), rerun after
// reset and after every configuration write.
// ----------------------------------------------------------------------------
module sswr_topcalc #(
  parameter int FRAC_BITS = 16,
  parameter int TOP_W     = 40
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          restart,
  input  logic [sswr_pkg::CIRC_W-1:0]   circ,
  input  logic [sswr_pkg::RATIO_W-1:0]  ratio,
  input  logic [sswr_pkg::MAXRPM_W-1:0] max_rpm,
  output logic                          busy,
  output logic [TOP_W-1:0]              top_spd
);

  localparam int PW   = sswr_pkg::CIRC_W + sswr_pkg::MAXRPM_W;
  localparam int NTW  = PW + FRAC_BITS;
  localparam int CNTW = $clog2(NTW);
  localparam int DENW = sswr_pkg::R60_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOAD = 3'b010,
    ST_RUN  = 3'b100
  } calc_state_t;

  calc_state_t     state;
  logic [NTW-1:0]  num;
  logic [DENW-1:0] den;
  logic [DENW-1:0] rem;
  logic [CNTW-1:0] cnt;
  logic [DENW:0]   trial;
  logic            ge;
  logic [DENW-1:0] rem_next;
  logic [NTW-1:0]  quo_next;
  logic            last;

  assign trial    = {rem, num[NTW-1]};
  assign ge       = trial >= {1'b0, den};
  assign rem_next = ge ? DENW'(trial - {1'b0, den}) : trial[DENW-1:0];
  assign quo_next = {num[NTW-2:0], ge};
  assign last     = cnt == CNTW'(NTW - 1);
  assign busy     = state != ST_IDLE;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      state <= ST_LOAD;
    end else begin
      case (state)
        ST_LOAD: state <= ST_RUN;
        ST_RUN:  if (last) state <= ST_IDLE;
        ST_IDLE: state <= ST_IDLE;
        default: state <= ST_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_LOAD: begin
        num <= {PW'(circ) * PW'(max_rpm), {FRAC_BITS{1'b0}}};
        den <= DENW'(ratio) * DENW'(sswr_pkg::RATIO_MUL);
        rem <= '0;
        cnt <= '0;
      end
      ST_RUN: begin
        rem <= rem_next;
        num <= quo_next;
        cnt <= cnt + 1'b1;
        // A top speed beyond the wheel speed range never triggers scaling.
        if (last) begin
          top_spd <= (quo_next[NTW-1:TOP_W] == '0) ? quo_next[TOP_W-1:0] : '1;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (rem < den))
    else $error("sswr_topcalc: partial remainder not below divisor");
`endif

endmodule

FILE: sv/skid_steer_wheel_rpm.sv
// ----------------------------------------------------------------------------
// Skid-steer wheel rpm
// Differential-drive inverse kinematics: velocity command to wheel rpm.
// ----------------------------------------------------------------------------
// A request (linear_speed, turn_rate) is taken at a rising edge where start
// is high and busy is low. One result per request appears on rpm_right and
// rpm_left for exactly one cycle with done high; results leave in request
// order and the receiver has no way to hold them off.
// The datapath is a fixed pipeline with two pipelined restoring dividers
// (one bit per stage: 56 - FRAC_BITS stages for the proportional scaling,
// 32 for rpm). A new request may enter in every cycle while busy is low.
// Registers are written through cfg_valid/cfg_ready with cfg_index and
// cfg_data; cfg_ready is always high. Write only while no request is in
// flight. Each write, and reset, starts a serial recompute of the top wheel
// speed, during which busy is high and no request is taken. Reset (rst,
// synchronous) restores the register defaults and empties the pipeline.
// ----------------------------------------------------------------------------
module skid_steer_wheel_rpm #(
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [31:0]              linear_speed,
  input  logic signed [31:0]              turn_rate,
  output logic                            done,
  output logic signed [31:0]              rpm_right,
  output logic signed [31:0]              rpm_left,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sswr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sswr_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int MAG_W   = sswr_pkg::MAG_W;
  localparam int CIRC_W  = sswr_pkg::CIRC_W;
  localparam int R60_W   = sswr_pkg::R60_W;
  // Track width times yaw rate magnitude, and the wheel speed magnitude.
  localparam int TPW     = sswr_pkg::TRACK_W + MAG_W;
  localparam int TMW     = TPW - FRAC_BITS - 1;
  localparam int SW      = TPW - FRAC_BITS;
  // Scaled speed times ratio*60 after dropping the fraction.
  localparam int XW      = SW + R60_W - FRAC_BITS;
  localparam int HW      = XW - 32;
  localparam int CMPW    = (HW > CIRC_W) ? HW : CIRC_W;
  localparam int SSIDE_W = 4 + 3 * SW;
  localparam int DSIDE_W = 4 + 2 * SW;

  // Configuration registers.
  logic                           safe_mode;
  logic [MAG_W-1:0]               linear_limit;
  logic [MAG_W-1:0]               angular_limit;
  logic [sswr_pkg::TRACK_W-1:0]   track_span;
  logic [sswr_pkg::RATIO_W-1:0]   gear_ratio;
  logic [CIRC_W-1:0]              wheel_circ;
  logic [sswr_pkg::MAXRPM_W-1:0]  motor_max_rpm;

  logic                           cfg_wr;
  logic [sswr_pkg::RATIO_W-1:0]   ratio_eff;
  logic [CIRC_W-1:0]              circ_eff;
  logic [R60_W-1:0]               r60;
  logic                           top_busy;
  logic [SW-1:0]                  top_spd;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign busy      = top_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      safe_mode     <= 1'b0;
      linear_limit  <= 31'd65536;
      angular_limit <= 31'd65536;
      track_span    <= 25'd32768;
      gear_ratio    <= 31'd65536;
      wheel_circ    <= 31'd65536;
      motor_max_rpm <= 16'd3000;
    end else if (cfg_wr) begin
      case (cfg_index)
        sswr_pkg::REG_SAFE_MODE:     safe_mode     <= cfg_data[0];
        sswr_pkg::REG_LINEAR_LIMIT:  linear_limit  <= cfg_data[MAG_W-1:0];
        sswr_pkg::REG_ANGULAR_LIMIT: angular_limit <= cfg_data[MAG_W-1:0];
        sswr_pkg::REG_TRACK_SPAN:    track_span    <= cfg_data[sswr_pkg::TRACK_W-1:0];
        sswr_pkg::REG_GEAR_RATIO:    gear_ratio    <= cfg_data[sswr_pkg::RATIO_W-1:0];
        sswr_pkg::REG_WHEEL_CIRC:    wheel_circ    <= cfg_data[CIRC_W-1:0];
        sswr_pkg::REG_MOTOR_MAX_RPM: motor_max_rpm <= cfg_data[sswr_pkg::MAXRPM_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero ratio or circumference is read as the smallest nonzero code.
  assign ratio_eff = (gear_ratio == '0) ? sswr_pkg::RATIO_W'(1) : gear_ratio;
  assign circ_eff  = (wheel_circ == '0) ? CIRC_W'(1) : wheel_circ;
  assign r60       = R60_W'(ratio_eff) * R60_W'(sswr_pkg::RATIO_MUL);

  sswr_topcalc #(
    .FRAC_BITS (FRAC_BITS),
    .TOP_W     (SW)
  ) u_topcalc (
    .clk     (clk),
    .rst     (rst),
    .restart (cfg_wr),
    .circ    (circ_eff),
    .ratio   (ratio_eff),
    .max_rpm (motor_max_rpm),
    .busy    (top_busy),
    .top_spd (top_spd)
  );

  // Stages A to D run on both commands side by side: index 0 is the linear
  // speed, index 1 the yaw rate. Magnitudes and signs are kept apart so the
  // truncating divisions work on unsigned values.
  logic             a_vld, b_vld, c_vld, d_vld;
  logic [31:0]      a_v   [2];
  logic             b_sgn [2];
  logic [31:0]      b_mag [2];
  logic [32:0]      b_x3  [2];
  logic             c_sgn [2];
  logic [31:0]      c_mag [2];
  logic [32:0]      c_x3  [2];
  logic [30:0]      c_est [2];
  logic             d_sgn [2];
  logic [MAG_W-1:0] d_mag [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
      d_vld <= 1'b0;
    end else begin
      a_vld <= start && !busy;
      b_vld <= a_vld;
      c_vld <= b_vld;
      d_vld <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      a_v[0] <= linear_speed;
      a_v[1] <= turn_rate;
    end
  end

  genvar j;
  for (j = 0; j < 2; j++) begin : g_cmd
    logic [31:0]      mag;
    logic [32:0]      rr;
    logic [30:0]      q5;
    logic [31:0]      v;
    logic [MAG_W-1:0] lim;

    assign mag = a_v[j][31] ? (~a_v[j] + 32'd1) : a_v[j];

    // Safe mode takes 3/5 of the magnitude: a reciprocal estimate that is
    // at most one low, then a single correction.
    assign rr  = c_x3[j] - (33'(c_est[j]) * 33'd5);
    assign q5  = c_est[j] + 31'(rr >= 33'd5);
    assign v   = safe_mode ? {1'b0, q5} : c_mag[j];
    assign lim = (j == 0) ? linear_limit : angular_limit;

    always_ff @(posedge clk) begin
      b_sgn[j] <= a_v[j][31];
      b_mag[j] <= mag;
      b_x3[j]  <= {1'b0, mag} + {mag, 1'b0};
      c_sgn[j] <= b_sgn[j];
      c_mag[j] <= b_mag[j];
      c_x3[j]  <= b_x3[j];
      c_est[j] <= 31'((65'(b_x3[j]) * 65'(sswr_pkg::DIV5_RECIP)) >> 32);
      d_sgn[j] <= c_sgn[j];
      d_mag[j] <= (v > {1'b0, lim}) ? lim : v[MAG_W-1:0];
    end
  end

  // Stage E: half-track term product. Stage F: wheel speeds.
  logic             e_vld, f_vld, g_vld;
  logic [TPW-1:0]   e_tprod;
  logic             e_sx, e_sw;
  logic [MAG_W-1:0] e_mx;
  logic [TMW-1:0]   tmag;
  logic signed [SW:0] vxs, ts, rs, ls;
  logic             f_sr, f_sl;
  logic [SW-1:0]    f_mr, f_ml;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
      f_vld <= 1'b0;
      g_vld <= 1'b0;
    end else begin
      e_vld <= d_vld;
      f_vld <= e_vld;
      g_vld <= f_vld;
    end
  end

  assign tmag = e_tprod[TPW-1:FRAC_BITS+1];
  assign vxs  = e_sx ? -$signed((SW+1)'(e_mx)) : $signed((SW+1)'(e_mx));
  assign ts   = e_sw ? -$signed((SW+1)'(tmag)) : $signed((SW+1)'(tmag));
  assign rs   = vxs - ts;
  assign ls   = vxs + ts;

  always_ff @(posedge clk) begin
    e_tprod <= TPW'(track_span) * TPW'(d_mag[1]);
    e_sx    <= d_sgn[0];
    e_sw    <= d_sgn[1];
    e_mx    <= d_mag[0];
    f_sr    <= rs[SW];
    f_sl    <= ls[SW];
    f_mr    <= rs[SW] ? SW'(-rs) : rs[SW-1:0];
    f_ml    <= ls[SW] ? SW'(-ls) : ls[SW-1:0];
  end

  // Stage G: proportional scaling decision. When no scaling is needed the
  // multiplier sees zero over one, keeping the divider precondition.
  logic          g_sr, g_sl, g_rsmall, g_scale;
  logic [SW-1:0] g_mr, g_ml, g_a, g_dvs;
  logic          rsmall_c, scale_c;
  logic [SW-1:0] mx_c;

  assign rsmall_c = f_mr <= f_ml;
  assign mx_c     = rsmall_c ? f_ml : f_mr;
  assign scale_c  = mx_c > top_spd;

  always_ff @(posedge clk) begin
    g_sr     <= f_sr;
    g_sl     <= f_sl;
    g_mr     <= f_mr;
    g_ml     <= f_ml;
    g_rsmall <= rsmall_c;
    g_scale  <= scale_c;
    g_a      <= scale_c ? (rsmall_c ? f_mr : f_ml) : '0;
    g_dvs    <= scale_c ? mx_c : SW'(1);
  end

  // The larger wheel becomes exactly the top speed; only the smaller one
  // needs smaller * top / larger.
  logic               sm_vld;
  logic [2*SW-1:0]    sm_prod;
  logic [SSIDE_W-1:0] sm_side;
  logic               sd_vld;
  logic [SW-1:0]      sd_quo;
  logic [DSIDE_W-1:0] sd_side;

  sswr_mul #(
    .AW     (SW),
    .BW     (SW),
    .SIDE_W (SSIDE_W)
  ) u_smul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (g_vld),
    .a         (g_a),
    .b         (top_spd),
    .in_side   ({g_sr, g_sl, g_rsmall, g_scale, g_mr, g_ml, g_dvs}),
    .out_valid (sm_vld),
    .prod      (sm_prod),
    .out_side  (sm_side)
  );

  sswr_div #(
    .QW     (SW),
    .DW     (SW),
    .SIDE_W (DSIDE_W)
  ) u_sdiv (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sm_vld),
    .in_rem    (sm_prod[2*SW-1:SW]),
    .in_num    (sm_prod[SW-1:0]),
    .in_dvs    (sm_side[SW-1:0]),
    .in_side   (sm_side[SSIDE_W-1:SW]),
    .out_valid (sd_vld),
    .quo       (sd_quo),
    .out_side  (sd_side)
  );

  // Stage H: final wheel ground speeds.
  logic          h_vld, h_scale;
  logic          h_sgn [2];
  logic [SW-1:0] h_mag [2];
  logic          s_sr, s_sl, s_rsmall, s_scale;
  logic [SW-1:0] s_mr, s_ml;

  assign {s_sr, s_sl, s_rsmall, s_scale, s_mr, s_ml} = sd_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_vld <= 1'b0;
    end else begin
      h_vld <= sd_vld;
    end
  end

  always_ff @(posedge clk) begin
    h_scale  <= s_scale;
    h_sgn[0] <= s_sr;
    h_sgn[1] <= s_sl;
    h_mag[0] <= s_scale ? (s_rsmall ? sd_quo : top_spd) : s_mr;
    h_mag[1] <= s_scale ? (s_rsmall ? top_spd : sd_quo) : s_ml;
  end

  // Rpm conversion, one lane per wheel (0 right, 1 left):
  // rpm = floor(floor(|s| * ratio * 60 / 2^FRAC) / circumference),
  // with an early overflow check so 32 quotient bits suffice.
  logic              i_vld [2];
  logic              i_sgn [2];
  logic              i_ovf [2];
  logic [CIRC_W-1:0] i_rem [2];
  logic [31:0]       i_lo  [2];
  logic              r_vld [2];
  logic [31:0]       rpm_q [2];

  for (j = 0; j < 2; j++) begin : g_rpm
    logic                  mv;
    logic [SW+R60_W-1:0]   mp;
    logic                  ms;
    logic [XW-1:0]         x;
    logic [CMPW-1:0]       hi_ext;
    logic                  ovf;
    logic                  dv;
    logic [31:0]           dq;
    logic [1:0]            dside;
    logic [32:0]           mm;

    sswr_mul #(
      .AW     (SW),
      .BW     (R60_W),
      .SIDE_W (1)
    ) u_rmul (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (h_vld),
      .a         (h_mag[j]),
      .b         (r60),
      .in_side   (h_sgn[j]),
      .out_valid (mv),
      .prod      (mp),
      .out_side  (ms)
    );

    assign x      = mp[SW+R60_W-1:FRAC_BITS];
    assign hi_ext = CMPW'(x[XW-1:32]);
    assign ovf    = hi_ext >= CMPW'(circ_eff);

    always_ff @(posedge clk) begin
      if (rst) begin
        i_vld[j] <= 1'b0;
      end else begin
        i_vld[j] <= mv;
      end
    end

    always_ff @(posedge clk) begin
      i_sgn[j] <= ms;
      i_ovf[j] <= ovf;
      i_rem[j] <= ovf ? '0 : hi_ext[CIRC_W-1:0];
      i_lo[j]  <= x[31:0];
    end

    sswr_div #(
      .QW     (32),
      .DW     (CIRC_W),
      .SIDE_W (2)
    ) u_rdiv (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (i_vld[j]),
      .in_rem    (i_rem[j]),
      .in_num    (i_lo[j]),
      .in_dvs    (circ_eff),
      .in_side   ({i_sgn[j], i_ovf[j]}),
      .out_valid (dv),
      .quo       (dq),
      .out_side  (dside)
    );

    // Saturate to the signed 32-bit range and apply the sign.
    assign mm = dside[0] ? 33'h1_0000_0000 : {1'b0, dq};

    assign r_vld[j] = dv;

    always_ff @(posedge clk) begin
      if (dside[1]) begin
        rpm_q[j] <= (mm > 33'h0_8000_0000) ? 32'h8000_0000 : 32'(-mm);
      end else begin
        rpm_q[j] <= (mm > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mm[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= r_vld[0];
    end
  end

  assign rpm_right = rpm_q[0];
  assign rpm_left  = rpm_q[1];

`ifndef SYNTHESIS
  // After proportional scaling neither wheel exceeds the top wheel speed.
  assert property (@(posedge clk) disable iff (rst)
    (h_vld && h_scale) |-> ((h_mag[0] <= top_spd) && (h_mag[1] <= top_spd)))
    else $error("skid_steer_wheel_rpm: scaled wheel speed above top speed");

  // Both rpm lanes stay in lockstep.
  assert property (@(posedge clk) disable iff (rst)
    i_vld[0] == i_vld[1])
    else $error("skid_steer_wheel_rpm: rpm lanes out of step");

  // The rpm divider gets an upper part below the circumference unless the
  // request already saturates.
  assert property (@(posedge clk) disable iff (rst)
    i_vld[0] |-> (i_ovf[0] || (i_rem[0] < circ_eff)))
    else $error("skid_steer_wheel_rpm: rpm divider precondition broken");
`endif

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// Skid-steer wheel rpm testbench
// Sends velocity requests with bursts and gaps, checks each wheel rpm result
// against a local fixed-point predictor, and walks several register settings.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDX_W = sswr_pkg::CFG_IDX_W;
  // Index with no register behind it; writes to it must change nothing.
  localparam logic [IDX_W-1:0] REG_NONE = 3'd7;
  // Longest stretch with no handshake of any kind before the run is called hung.
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 120;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic signed [31:0] linear_speed;
  logic signed [31:0] turn_rate;
  logic done;
  logic signed [31:0] rpm_right;
  logic signed [31:0] rpm_left;
  logic cfg_valid;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index;
  logic [sswr_pkg::CFG_DATA_W-1:0] cfg_data;

  skid_steer_wheel_rpm u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .linear_speed(linear_speed), .turn_rate(turn_rate),
    .done(done), .rpm_right(rpm_right), .rpm_left(rpm_left),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  typedef struct packed {
    logic signed [31:0] right;
    logic signed [31:0] left;
  } wheel_rpm_t;

  // Shadow copy of the register file, held at 64 bits for the arithmetic.
  logic [63:0] safe_on, lin_max, ang_max, track, ratio_reg, circ_reg, rpm_max;

  wheel_rpm_t rpm_queue[$];
  int mismatches;
  int idle_cycles;

  // The request being driven can carry a hand-typed expectation instead of
  // the predicted one; the monitor picks whichever applies when it is taken.
  logic       drv_typed;
  wheel_rpm_t drv_expect;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // floor(a*b/d) over a 128-bit product, all ones when d is zero or it does not fit.
  function automatic logic [63:0] scale_div(logic [63:0] a, logic [63:0] b,
                                            logic [63:0] d);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    if (d == 64'd0 || prod[127:64] >= d) return '1;
    return 64'(prod / {64'd0, d});
  endfunction

  function automatic logic [63:0] magnitude(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // Ground speed in Q16.16 to motor rpm, saturated to 32 bits.
  function automatic logic [31:0] speed_to_rpm(longint s, logic [63:0] ratio,
                                               logic [63:0] circ);
    logic [63:0] m;
    m = scale_div(magnitude(s), ratio * 64'd60, circ << 16);
    if (s < 0) begin
      if (m > 64'h8000_0000) m = 64'h8000_0000;
      return 32'(-m);
    end
    if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
    return m[31:0];
  endfunction

  function automatic wheel_rpm_t wheel_rpm(logic signed [31:0] lin,
                                           logic signed [31:0] ang);
    longint vx, vw, half, rs, ls;
    logic [63:0] ratio, circ, top, mr, ml, mx;
    wheel_rpm_t res;
    vx = lin;
    vw = ang;
    ratio = (ratio_reg == 0) ? 64'd1 : ratio_reg;
    circ = (circ_reg == 0) ? 64'd1 : circ_reg;
    if (safe_on[0]) begin
      vx = vx * 3 / 5;
      vw = vw * 3 / 5;
    end
    if (magnitude(vx) > lin_max) vx = vx < 0 ? -longint'(lin_max) : longint'(lin_max);
    if (magnitude(vw) > ang_max) vw = vw < 0 ? -longint'(ang_max) : longint'(ang_max);
    half = longint'((track * magnitude(vw)) >> 17);
    if (vw < 0) half = -half;
    rs = vx - half;
    ls = vx + half;
    top = scale_div(circ * rpm_max, 64'd1 << 16, ratio * 64'd60);
    mr = magnitude(rs);
    ml = magnitude(ls);
    mx = (mr > ml) ? mr : ml;
    if (mx > top) begin
      mr = scale_div(mr, top, mx);
      ml = scale_div(ml, top, mx);
      rs = rs < 0 ? -longint'(mr) : longint'(mr);
      ls = ls < 0 ? -longint'(ml) : longint'(ml);
    end
    res.right = speed_to_rpm(rs, ratio, circ);
    res.left = speed_to_rpm(ls, ratio, circ);
    return res;
  endfunction

  task automatic reset_shadow();
    safe_on = 0; lin_max = 65536; ang_max = 65536; track = 32768;
    ratio_reg = 65536; circ_reg = 65536; rpm_max = 3000;
  endtask

  // Monitor: inputs settle at the falling edge, so the rising edge sees
  // stable values on both sides.
  always @(posedge clk) begin
    wheel_rpm_t want;
    if (!rst) begin
      if (start && !busy)
        rpm_queue.insert(rpm_queue.size(),
                         drv_typed ? drv_expect : wheel_rpm(linear_speed, turn_rate));
      if (done) begin
        if (rpm_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result right=%0d left=%0d", rpm_right, rpm_left);
        end else begin
          want = rpm_queue.pop_front();
          if (want.right !== rpm_right || want.left !== rpm_left) begin
            mismatches++;
            if (mismatches <= 10)
              $display("rpm mismatch: expected right=%0d left=%0d, got right=%0d left=%0d",
                       want.right, want.left, rpm_right, rpm_left);
          end
        end
      end
    end
  end

  // Watchdog: any handshake or result counts as progress.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[skid_steer_wheel_rpm] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Drops start and waits for every outstanding result. Every request makes
  // exactly one result, so an empty queue means the pipeline is empty too.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (rpm_queue.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      sswr_pkg::REG_SAFE_MODE:     safe_on = val & 64'h1;
      sswr_pkg::REG_LINEAR_LIMIT:  lin_max = val & 64'h7FFF_FFFF;
      sswr_pkg::REG_ANGULAR_LIMIT: ang_max = val & 64'h7FFF_FFFF;
      sswr_pkg::REG_TRACK_SPAN:    track = val & 64'h1FF_FFFF;
      sswr_pkg::REG_GEAR_RATIO:    ratio_reg = val & 64'h7FFF_FFFF;
      sswr_pkg::REG_WHEEL_CIRC:    circ_reg = val & 64'h7FFF_FFFF;
      sswr_pkg::REG_MOTOR_MAX_RPM: rpm_max = val & 64'hFFFF;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Holds start high from the falling edge until the block takes the request.
  task automatic send(logic signed [31:0] lin, logic signed [31:0] ang,
                      logic typed, wheel_rpm_t want);
    @(negedge clk);
    start <= 1'b1;
    linear_speed <= lin;
    turn_rate <= ang;
    drv_typed <= typed;
    drv_expect <= want;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Directed table: a row is either a register write or a request, and a
  // request may carry a typed expectation.
  typedef struct {
    bit          is_write;
    logic [2:0]  idx;
    logic [31:0] val;
    bit          typed;
    int          exp_right;
    int          exp_left;
  } step_t;

  localparam logic [31:0] SMAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SMIN = 32'h8000_0000;

  step_t steps[] = '{
    // Defaults: zero command, then 1 m/s straight, which is 60 rpm per wheel.
    '{0, 0, 0, 1, 0, 0},
    '{0, 0, 32'h0001_0000, 1, 60, 60},
    '{0, 0, SMAX, 0, 0, 0},
    '{0, 0, SMIN, 0, 0, 0},
    '{0, 0, 32'hFFFF_0000, 0, 0, 0},
    // Safe mode scales both commands by 0.6.
    '{1, sswr_pkg::REG_SAFE_MODE, 32'hFFFF_FFFF, 0, 0, 0},
    '{0, 0, 32'h0001_0000, 0, 0, 0},
    '{0, 0, SMIN, 0, 0, 0},
    '{1, sswr_pkg::REG_SAFE_MODE, 0, 0, 0, 0},
    // Widest limits and track; oversized values are masked.
    '{1, sswr_pkg::REG_LINEAR_LIMIT, 32'hFFFF_FFFF, 0, 0, 0},
    '{1, sswr_pkg::REG_ANGULAR_LIMIT, SMAX, 0, 0, 0},
    '{1, sswr_pkg::REG_TRACK_SPAN, 32'hFFFF_FFFF, 0, 0, 0},
    '{0, 0, SMAX, 0, 0, 0},
    '{0, 0, SMIN, 0, 0, 0},
    // Zero ratio and zero circumference both read as one.
    '{1, sswr_pkg::REG_GEAR_RATIO, 0, 0, 0, 0},
    '{1, sswr_pkg::REG_WHEEL_CIRC, 0, 0, 0, 0},
    '{0, 0, 32'h0000_1234, 0, 0, 0},
    // Huge top speed: no proportional scaling at all.
    '{1, sswr_pkg::REG_WHEEL_CIRC, SMAX, 0, 0, 0},
    '{1, sswr_pkg::REG_MOTOR_MAX_RPM, 32'hFFFF, 0, 0, 0},
    '{0, 0, SMAX, 0, 0, 0},
    // Large ratio, tiny wheel: the top speed is zero, so every wheel stops.
    '{1, sswr_pkg::REG_GEAR_RATIO, SMAX, 0, 0, 0},
    '{1, sswr_pkg::REG_WHEEL_CIRC, 1, 0, 0, 0},
    '{0, 0, SMAX, 0, 0, 0},
    '{0, 0, SMIN, 0, 0, 0},
    // Zero max rpm stops every wheel.
    '{1, sswr_pkg::REG_MOTOR_MAX_RPM, 0, 0, 0, 0},
    '{0, 0, SMAX, 1, 0, 0},
    '{0, 0, 32'h0001_0000, 1, 0, 0},
    // A write to an unused index changes nothing.
    '{1, REG_NONE, 32'h0000_0BB8, 0, 0, 0},
    '{0, 0, 32'h0001_0000, 1, 0, 0}
  };

  // Turn rate for each request row, paired by position in the table.
  logic [31:0] turn_col[] = '{
    0, 0, SMIN, SMAX, 32'h0001_0000,
    0, 0, SMAX, 0,
    0, 0, 0, SMIN, SMAX,
    0, 0, 32'hFFFF_0000,
    0, 0, SMIN,
    0, 0, SMIN, SMIN,
    0, SMIN, 0,
    0, 32'h0000_8000
  };

  function automatic logic [31:0] pick_reg(logic [IDX_W-1:0] idx);
    int k;
    k = $urandom_range(0, 5);
    case (idx)
      sswr_pkg::REG_SAFE_MODE:     return $urandom;
      sswr_pkg::REG_LINEAR_LIMIT,
      sswr_pkg::REG_ANGULAR_LIMIT: return k == 0 ? 0 : k == 1 ? SMAX :
                                          $urandom_range(1, 32'h0008_0000);
      sswr_pkg::REG_TRACK_SPAN:    return k == 0 ? 0 : k == 1 ? 32'h1FF_FFFF :
                                          $urandom_range(1, 32'h0004_0000);
      sswr_pkg::REG_GEAR_RATIO,
      sswr_pkg::REG_WHEEL_CIRC:    return k == 0 ? 0 : k == 1 ? SMAX :
                                          $urandom_range(1, 32'h0040_0000);
      default:                     return k == 0 ? 0 : k == 1 ? 32'hFFFF :
                                          $urandom_range(1, 6000);
    endcase
  endfunction

  function automatic logic [31:0] pick_speed();
    // Mostly commands near the working range; the rest span the full field.
    case ($urandom_range(0, 3))
      0: return $urandom;
      default: return $urandom_range(0, 32'h0006_0000) - 32'h0003_0000;
    endcase
  endfunction

  initial begin
    wheel_rpm_t want;
    int left_in_burst, quiet;
    rst = 1'b1;
    start = 1'b0;
    linear_speed = '0;
    turn_rate = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    drv_typed = 1'b0;
    drv_expect = '0;
    reset_shadow();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table.
    foreach (steps[row]) begin
      if (steps[row].is_write) begin
        drain();
        write_reg(steps[row].idx, steps[row].val);
      end else begin
        want.right = steps[row].exp_right;
        want.left = steps[row].exp_left;
        send(steps[row].val, turn_col[row], steps[row].typed, want);
      end
    end

    // Random phases: each starts from an idle block with a fresh setting.
    for (int phase = 0; phase < 8; phase++) begin
      drain();
      for (int r = 0; r < 7; r++) write_reg(IDX_W'(r), pick_reg(IDX_W'(r)));
      if (phase == 3) write_reg(REG_NONE, $urandom);
      quiet = (phase % 3 == 0);  // some phases run back to back, no gaps
      left_in_burst = 0;
      for (int n = 0; n < 200; n++) begin
        if (left_in_burst == 0) begin
          left_in_burst = $urandom_range(1, 40);
          if (!quiet) pause($urandom_range(1, 12));
        end
        left_in_burst--;
        send(pick_speed(), pick_speed(), 1'b0, '0);
        // Pause once per phase until everything in flight has come back.
        if (n == 100) drain();
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && rpm_queue.size() == 0) begin
      $display("[skid_steer_wheel_rpm] OK");
    end else begin
      $display("[skid_steer_wheel_rpm] ERROR");
    end
    $finish;
  end

endmodule
